>>> design/cdu_pkg.sv
// ----------------------------------------------------------------------------
// cdu_pkg
// Shared types, constants and calendar helper functions for the date unit.
// ----------------------------------------------------------------------------
package cdu_pkg;

	// width of the day counter; the day_count field is 16 bits wide
	localparam int COUNT_BITS = 16;
	localparam int COUNT_EXT  = 24;

	typedef enum logic [1:0] {
		CMD_SET = 2'd0,
		CMD_ADD = 2'd1,
		CMD_SUB = 2'd2,
		CMD_CMP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_DATE  = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	localparam logic [13:0] YEAR_MIN   = 14'd1;
	localparam logic [13:0] YEAR_MAX   = 14'd9999;
	localparam logic [13:0] YEAR_RESET = 14'd2000;
	localparam logic [13:0] YEAR_SHIFT = 14'd4800;
	localparam logic [3:0]  MONTH_JAN  = 4'd1;
	localparam logic [3:0]  MONTH_FEB  = 4'd2;
	localparam logic [3:0]  MONTH_DEC  = 4'd12;
	localparam logic [4:0]  DAY_FIRST  = 5'd1;
	localparam logic [4:0]  DAY_DEC_END = 5'd31;
	localparam logic [15:0] JDN_BIAS   = 16'd32045;
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam logic [8:0]  DAYS_YEAR  = 9'd365;
	localparam logic [6:0]  HUNDRED    = 7'd100;

	localparam logic [4:0] MONTH_LEN [13] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef struct packed {
		logic load_in;
		logic load_held;
		logic step;
		logic set_err_date;
		logic set_err_range;
		logic jdn_start;
		logic jdn_sel_given;
		logic cap_given;
		logic cap_held;
		logic load_out;
	} cdu_ctl_t;

	typedef struct packed {
		cmd_t cmd;
		logic given_ok;
		logic count_zero;
		logic at_limit;
		logic jdn_done;
	} cdu_sts_t;

	// floor(x / 100) for x < 16384 by reciprocal multiply
	function automatic logic [7:0] div100(input logic [13:0] x);
		logic [26:0] p;
		p = 27'(x) * 27'(RECIP_100);
		return p[26:19];
	endfunction

	// q100 must be floor(y / 100)
	function automatic logic is_leap(input logic [13:0] y, input logic [7:0] q100);
		logic [14:0] hund;
		hund = 15'(q100) * 15'(HUNDRED);
		return (y[1:0] == 2'b00) && ((15'(y) != hund) || (q100[1:0] == 2'b00));
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		n = 5'd0;
		if (m >= MONTH_JAN && m <= MONTH_DEC) begin
			n = MONTH_LEN[m];
		end
		if (m == MONTH_FEB && leap) begin
			n = n + 5'd1;
		end
		return n;
	endfunction

	// (153 * m' + 2) / 5 with the year starting in march
	function automatic logic [8:0] month_offset(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd306;
			4'd2:    r = 9'd337;
			4'd3:    r = 9'd0;
			4'd4:    r = 9'd31;
			4'd5:    r = 9'd61;
			4'd6:    r = 9'd92;
			4'd7:    r = 9'd122;
			4'd8:    r = 9'd153;
			4'd9:    r = 9'd184;
			4'd10:   r = 9'd214;
			4'd11:   r = 9'd245;
			4'd12:   r = 9'd275;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> design/cdu_if.sv
// ----------------------------------------------------------------------------
// cdu_if
// Valid/ready channels of the date unit: command channel and result channel.
// ----------------------------------------------------------------------------
interface cdu_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [4:0]  day_in;
	logic [3:0]  month_in;
	logic [13:0] year_in;
	logic [15:0] day_count;

	modport source(output valid, command, day_in, month_in, year_in, day_count,
		input ready);
	modport sink(input valid, command, day_in, month_in, year_in, day_count,
		output ready);
endinterface

interface cdu_res_if;
	logic               valid;
	logic               ready;
	logic [4:0]         cur_day;
	logic [3:0]         cur_month;
	logic [13:0]        cur_year;
	logic [22:0]        day_number;
	logic [2:0]         weekday;
	logic signed [22:0] difference;
	logic [1:0]         error;

	modport source(output valid, cur_day, cur_month, cur_year, day_number, weekday,
		difference, error, input ready);
	modport sink(input valid, cur_day, cur_month, cur_year, day_number, weekday,
		difference, error, output ready);
endinterface

>>> design/calendar_date_unit_top.sv
// ----------------------------------------------------------------------------
// calendar_date_unit_top
// Gregorian date register with set, day stepping, compare and day number.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command beat (set, add days, subtract days, compare) with
//   a date and a day count; result returns exactly one beat per command with
//   the held date, its Julian Day Number, weekday (0 = Monday), difference
//   and error code. Both channels use valid/ready.
//   An add or subtract walks the held date one day per cycle until the count
//   runs out or the range end stops the walk early. The day number pipeline
//   then runs for the held date, after a first pass for the given date on a
//   valid compare; one command is in work at a time.
//   cmd is ready again as soon as the result is loaded into the output
//   register, so the next command is taken while that beat waits.
//   If result stalls, the finished command holds in its last state until the
//   output register frees; nothing is dropped.
//   Reset clears control and loads the held date 1-1-2000.
// ----------------------------------------------------------------------------
module calendar_date_unit_top import cdu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	cdu_cmd_if.sink   cmd,
	cdu_res_if.source result
);

	cdu_ctl_t ctl;
	cdu_sts_t st;

	cdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.ctl       (ctl)
	);

	cdu_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (cmd.command),
		.day_in     (cmd.day_in),
		.month_in   (cmd.month_in),
		.year_in    (cmd.year_in),
		.day_count  (cmd.day_count),
		.ctl        (ctl),
		.st         (st),
		.cur_day    (result.cur_day),
		.cur_month  (result.cur_month),
		.cur_year   (result.cur_year),
		.day_number (result.day_number),
		.weekday    (result.weekday),
		.difference (result.difference),
		.error      (result.error)
	);

endmodule

>>> design/cdu_jdn.sv
// ----------------------------------------------------------------------------
// cdu_jdn
// Six-stage Julian Day Number and weekday pipeline for one valid date.
// ----------------------------------------------------------------------------
module cdu_jdn import cdu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [4:0]  day,
	input  logic [3:0]  month,
	input  logic [13:0] year,
	output logic        done,
	output logic [22:0] jdn,
	output logic [2:0]  weekday
);

	logic [5:0]  tok_q;
	logic [13:0] yy_s1;
	logic [8:0]  dm_s1;
	logic [22:0] p365_s2;
	logic [11:0] q4_s2;
	logic [7:0]  q100_s2;
	logic [5:0]  q400_s2;
	logic [8:0]  dm_s2;
	logic [22:0] pos_s3;
	logic [15:0] neg_s3;
	logic [22:0] jdn_s4;
	logic [22:0] jdn_s5;
	logic [5:0]  dsum_s5;
	logic [22:0] jdn_s6;
	logic [2:0]  wd_s6;

	logic        early;
	logic [13:0] yy;
	logic [7:0]  q400_full;
	logic [23:0] jdn_ext;
	logic [5:0]  dsum;
	logic [3:0]  fold;

	always_comb begin
		early = (month <= MONTH_FEB);
		yy    = year + YEAR_SHIFT - 14'(early);
	end

	assign q400_full = div100({2'b00, yy_s1[13:2]});

	// 8 = 1 mod 7, so the octal digit sum keeps the remainder
	always_comb begin
		jdn_ext = {1'b0, jdn_s4};
		dsum = 6'd0;
		for (int i = 0; i < 8; i++) begin
			dsum = dsum + 6'(jdn_ext[3*i +: 3]);
		end
		fold = 4'(dsum_s5[5:3]) + 4'(dsum_s5[2:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= {tok_q[4:0], start};
		end
	end

	always_ff @(posedge clk) begin
		yy_s1   <= yy;
		dm_s1   <= 9'(day) + month_offset(month);

		p365_s2 <= 23'(yy_s1) * 23'(DAYS_YEAR);
		q4_s2   <= yy_s1[13:2];
		q100_s2 <= div100(yy_s1);
		q400_s2 <= q400_full[5:0];
		dm_s2   <= dm_s1;

		pos_s3  <= p365_s2 + 23'(q4_s2) + 23'(dm_s2);
		neg_s3  <= 16'(q100_s2) - 16'(q400_s2) + JDN_BIAS;

		jdn_s4  <= pos_s3 - 23'(neg_s3);

		jdn_s5  <= jdn_s4;
		dsum_s5 <= dsum;

		jdn_s6  <= jdn_s5;
		wd_s6   <= (fold >= 4'd7) ? 3'(fold - 4'd7) : 3'(fold);
	end

	assign done    = tok_q[5];
	assign jdn     = jdn_s6;
	assign weekday = wd_s6;

endmodule

>>> design/cdu_dp.sv
// ----------------------------------------------------------------------------
// cdu_dp
// Datapath: held date, day stepper, date check, day number unit, result regs.
// ----------------------------------------------------------------------------
module cdu_dp import cdu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         command,
	input  logic [4:0]         day_in,
	input  logic [3:0]         month_in,
	input  logic [13:0]        year_in,
	input  logic [15:0]        day_count,
	input  cdu_ctl_t           ctl,
	output cdu_sts_t           st,
	output logic [4:0]         cur_day,
	output logic [3:0]         cur_month,
	output logic [13:0]        cur_year,
	output logic [22:0]        day_number,
	output logic [2:0]         weekday,
	output logic signed [22:0] difference,
	output logic [1:0]         error
);

	cmd_t                  cmd_q;
	logic [4:0]            d_q;
	logic [3:0]            m_q;
	logic [13:0]           y_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [7:0]            gq100_q;
	logic                  given_ok_q;

	logic [4:0]            held_day_q;
	logic [3:0]            held_month_q;
	logic [13:0]           held_year_q;
	logic [13:0]           hyear_s1;
	logic [7:0]            hq100_s1;
	logic                  leap_s2;

	err_t                  err_q;
	logic                  diff_ok_q;
	logic [22:0]           gjdn_q;
	logic [22:0]           jdn_q;
	logic [2:0]            wd_q;

	logic [4:0]            out_day_q;
	logic [3:0]            out_month_q;
	logic [13:0]           out_year_q;
	logic [22:0]           out_jdn_q;
	logic [2:0]            out_wd_q;
	logic [22:0]           out_diff_q;
	err_t                  out_err_q;

	logic [COUNT_EXT-1:0]  count_ext;
	logic                  leap_given;
	logic                  given_ok;
	logic [4:0]            dim_cur;
	logic [4:0]            dim_prev;
	logic                  add_limit;
	logic                  sub_limit;
	logic                  jdn_done;
	logic [22:0]           jdn_res;
	logic [2:0]            wd_res;
	logic [4:0]            jd;
	logic [3:0]            jm;
	logic [13:0]           jy;

	assign count_ext = COUNT_EXT'(day_count);

	always_comb begin
		leap_given = is_leap(y_q, gq100_q);
		given_ok = (y_q >= YEAR_MIN) && (y_q <= YEAR_MAX)
			&& (m_q >= MONTH_JAN) && (m_q <= MONTH_DEC)
			&& (d_q >= DAY_FIRST) && (d_q <= month_days(m_q, leap_given));
		dim_cur  = month_days(held_month_q, leap_s2);
		dim_prev = month_days(held_month_q - 4'd1, leap_s2);
		add_limit = (held_day_q >= dim_cur) && (held_month_q == MONTH_DEC)
			&& (held_year_q >= YEAR_MAX);
		sub_limit = (held_day_q <= DAY_FIRST) && (held_month_q <= MONTH_JAN)
			&& (held_year_q <= YEAR_MIN);
	end

	always_comb begin
		st.cmd        = cmd_q;
		st.given_ok   = given_ok_q;
		st.count_zero = (count_q == '0);
		st.at_limit   = (cmd_q == CMD_ADD) ? add_limit : sub_limit;
		st.jdn_done   = jdn_done;
	end

	// the held leap flag trails the held year through hyear_s1 and leap_s2; february is
	// always at least a month of steps away from a year change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_day_q   <= DAY_FIRST;
			held_month_q <= MONTH_JAN;
			held_year_q  <= YEAR_RESET;
			hyear_s1     <= YEAR_RESET;
			hq100_s1     <= div100(YEAR_RESET);
			leap_s2      <= 1'b1;
		end else begin
			hyear_s1 <= held_year_q;
			hq100_s1 <= div100(held_year_q);
			leap_s2  <= is_leap(hyear_s1, hq100_s1);
			if (ctl.load_held) begin
				held_day_q   <= d_q;
				held_month_q <= m_q;
				held_year_q  <= y_q;
			end else if (ctl.step) begin
				if (cmd_q == CMD_ADD) begin
					if (held_day_q >= dim_cur) begin
						if (held_month_q == MONTH_DEC) begin
							held_year_q  <= held_year_q + 14'd1;
							held_month_q <= MONTH_JAN;
						end else begin
							held_month_q <= held_month_q + 4'd1;
						end
						held_day_q <= DAY_FIRST;
					end else begin
						held_day_q <= held_day_q + 5'd1;
					end
				end else begin
					if (held_day_q > DAY_FIRST) begin
						held_day_q <= held_day_q - 5'd1;
					end else if (held_month_q > MONTH_JAN) begin
						held_month_q <= held_month_q - 4'd1;
						held_day_q   <= dim_prev;
					end else begin
						held_year_q  <= held_year_q - 14'd1;
						held_month_q <= MONTH_DEC;
						held_day_q   <= DAY_DEC_END;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		gq100_q    <= div100(y_q);
		given_ok_q <= given_ok;
		if (ctl.load_in) begin
			cmd_q     <= cmd_t'(command);
			d_q       <= day_in;
			m_q       <= month_in;
			y_q       <= year_in;
			count_q   <= count_ext[COUNT_BITS-1:0];
			err_q     <= ERR_NONE;
			diff_ok_q <= 1'b0;
		end else begin
			if (ctl.step) begin
				count_q <= count_q - COUNT_BITS'(1);
			end
			if (ctl.set_err_date) begin
				err_q <= ERR_DATE;
			end else if (ctl.set_err_range) begin
				err_q <= ERR_RANGE;
			end
			if (ctl.cap_given) begin
				gjdn_q    <= jdn_res;
				diff_ok_q <= 1'b1;
			end
		end
		if (ctl.cap_held) begin
			jdn_q <= jdn_res;
			wd_q  <= wd_res;
		end
		if (ctl.load_out) begin
			out_day_q   <= held_day_q;
			out_month_q <= held_month_q;
			out_year_q  <= held_year_q;
			out_jdn_q   <= jdn_q;
			out_wd_q    <= wd_q;
			out_diff_q  <= diff_ok_q ? (jdn_q - gjdn_q) : 23'd0;
			out_err_q   <= err_q;
		end
	end

	always_comb begin
		jd = ctl.jdn_sel_given ? d_q : held_day_q;
		jm = ctl.jdn_sel_given ? m_q : held_month_q;
		jy = ctl.jdn_sel_given ? y_q : held_year_q;
	end

	cdu_jdn u_jdn (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctl.jdn_start),
		.day     (jd),
		.month   (jm),
		.year    (jy),
		.done    (jdn_done),
		.jdn     (jdn_res),
		.weekday (wd_res)
	);

	assign cur_day    = out_day_q;
	assign cur_month  = out_month_q;
	assign cur_year   = out_year_q;
	assign day_number = out_jdn_q;
	assign weekday    = out_wd_q;
	assign difference = $signed(out_diff_q);
	assign error      = out_err_q;

endmodule

>>> design/cdu_ctrl.sv
// ----------------------------------------------------------------------------
// cdu_ctrl
// Command sequencer: check, step loop, day number passes and result hand-off.
// ----------------------------------------------------------------------------
module cdu_ctrl import cdu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  cdu_sts_t st,
	output cdu_ctl_t ctl
);

	typedef enum logic [8:0] {
		ST_IDLE       = 9'b000000001,
		ST_CHECK1     = 9'b000000010,
		ST_CHECK2     = 9'b000000100,
		ST_BRANCH     = 9'b000001000,
		ST_STEP       = 9'b000010000,
		ST_GIVEN_WAIT = 9'b000100000,
		ST_HELD_START = 9'b001000000,
		ST_HELD_WAIT  = 9'b010000000,
		ST_FINISH     = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load_in = 1'b1;
					state_nxt   = ST_CHECK1;
				end
			end
			// date check runs in the datapath across ST_CHECK1 and ST_CHECK2
			ST_CHECK1: state_nxt = ST_CHECK2;
			ST_CHECK2: state_nxt = ST_BRANCH;
			ST_BRANCH: begin
				unique case (st.cmd) inside
					CMD_SET: begin
						ctl.load_held    = st.given_ok;
						ctl.set_err_date = !st.given_ok;
						state_nxt        = ST_HELD_START;
					end
					CMD_CMP: begin
						if (st.given_ok) begin
							ctl.jdn_start     = 1'b1;
							ctl.jdn_sel_given = 1'b1;
							state_nxt         = ST_GIVEN_WAIT;
						end else begin
							ctl.set_err_date = 1'b1;
							state_nxt        = ST_HELD_START;
						end
					end
					CMD_ADD, CMD_SUB: state_nxt = ST_STEP;
					default: state_nxt = ST_HELD_START;
				endcase
			end
			ST_STEP: begin
				if (st.count_zero) begin
					state_nxt = ST_HELD_START;
				end else if (st.at_limit) begin
					ctl.set_err_range = 1'b1;
					state_nxt         = ST_HELD_START;
				end else begin
					ctl.step = 1'b1;
				end
			end
			ST_GIVEN_WAIT: begin
				if (st.jdn_done) begin
					ctl.cap_given = 1'b1;
					state_nxt     = ST_HELD_START;
				end
			end
			ST_HELD_START: begin
				ctl.jdn_start = 1'b1;
				state_nxt     = ST_HELD_WAIT;
			end
			ST_HELD_WAIT: begin
				if (st.jdn_done) begin
					ctl.cap_held = 1'b1;
					state_nxt    = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_step_legal: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step |-> (!st.count_zero && !st.at_limit))
		else $error("step issued with zero count or at range limit");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		st.jdn_done |-> (state_q == ST_GIVEN_WAIT || state_q == ST_HELD_WAIT))
		else $error("day number result arrived outside a wait state");

	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CHECK1))
		else $error("accepted beat did not start the date check");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result load did not raise valid");

endmodule

>>> tb/sv/calendar_date_unit_top_tb.sv
// ----------------------------------------------------------------------------
// calendar_date_unit_top_tb
// Drives set, add, subtract and compare commands into the date unit with
// random gaps and result back-pressure. Every result beat is checked field
// by field against an in-bench calendar predictor or a typed-in value.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module calendar_date_unit_top_tb import cdu_pkg::*; ();

	typedef struct packed {
		cmd_t        command;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [15:0] count;
	} date_cmd_t;

	typedef struct packed {
		logic [4:0]         cur_day;
		logic [3:0]         cur_month;
		logic [13:0]        cur_year;
		logic [22:0]        day_number;
		logic [2:0]         weekday;
		logic signed [22:0] difference;
		err_t               error;
	} date_result_t;

	typedef struct packed {
		date_cmd_t    op;
		logic         typed;
		date_result_t want;
	} table_row_t;

	localparam int ROWS = 24;
	localparam int RANDOM_ITEMS = 76;

	// results readable without arithmetic: the reset date and both range ends
	localparam date_result_t JAN_2000 =
		'{5'd1, 4'd1, 14'd2000, 23'd2451545, 3'd5, 23'sd0, ERR_NONE};
	localparam date_result_t JAN_2000_BAD =
		'{5'd1, 4'd1, 14'd2000, 23'd2451545, 3'd5, 23'sd0, ERR_DATE};
	localparam date_result_t LAST_DAY =
		'{5'd31, 4'd12, 14'd9999, 23'd5373484, 3'd4, 23'sd0, ERR_NONE};
	localparam date_result_t LAST_DAY_STOP =
		'{5'd31, 4'd12, 14'd9999, 23'd5373484, 3'd4, 23'sd0, ERR_RANGE};
	localparam date_result_t FIRST_DAY =
		'{5'd1, 4'd1, 14'd1, 23'd1721426, 3'd0, 23'sd0, ERR_NONE};
	localparam date_result_t FIRST_DAY_STOP =
		'{5'd1, 4'd1, 14'd1, 23'd1721426, 3'd0, 23'sd0, ERR_RANGE};
	localparam date_result_t FIRST_VS_LAST =
		'{5'd1, 4'd1, 14'd1, 23'd1721426, 3'd0, -23'sd3652058, ERR_NONE};

	logic clk = 1'b0;
	logic arst_n;

	cdu_cmd_if cmd();
	cdu_res_if result();

	calendar_date_unit_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.result (result)
	);

	// predictor copy of the held date
	int cal_day;
	int cal_month;
	int cal_year;

	date_result_t pending_results[$];
	table_row_t   dir_rows [ROWS];
	int idle_max;
	int large_left;
	int fail_count;
	int beats_per_cmd [4];
	int date_errs;
	int range_stops;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic bit leap_year(int y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int month_length(int y, int m);
		int len [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		if (m < 1 || m > 12) begin
			return 0;
		end
		return (m == 2 && leap_year(y)) ? 29 : len[m];
	endfunction

	function automatic bit date_ok(int d, int m, int y);
		if (y < 1 || y > 9999 || m < 1 || m > 12) begin
			return 1'b0;
		end
		return d >= 1 && d <= month_length(y, m);
	endfunction

	function automatic int julian_day(int d, int m, int y);
		int a;
		int yy;
		int mm;
		a = (14 - m) / 12;
		yy = y + 4800 - a;
		mm = m + 12 * a - 3;
		return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
	endfunction

	// applies one command to the predicted date and returns the beat it causes
	function automatic date_result_t advance_calendar(date_cmd_t c);
		int n;
		int diff;
		int jd;
		err_t err;
		date_result_t r;
		n = c.count;
		diff = 0;
		err = ERR_NONE;
		case (c.command)
			CMD_SET: begin
				if (date_ok(c.day, c.month, c.year)) begin
					cal_day = c.day;
					cal_month = c.month;
					cal_year = c.year;
				end else begin
					err = ERR_DATE;
				end
			end
			CMD_ADD: begin
				while (n > 0) begin
					if (cal_day >= month_length(cal_year, cal_month)) begin
						if (cal_month == 12) begin
							if (cal_year >= 9999) begin
								err = ERR_RANGE;
								break;
							end
							cal_year++;
							cal_month = 1;
						end else begin
							cal_month++;
						end
						cal_day = 1;
					end else begin
						cal_day++;
					end
					n--;
				end
			end
			CMD_SUB: begin
				while (n > 0) begin
					if (cal_day > 1) begin
						cal_day--;
					end else if (cal_month > 1) begin
						cal_month--;
						cal_day = month_length(cal_year, cal_month);
					end else begin
						if (cal_year <= 1) begin
							err = ERR_RANGE;
							break;
						end
						cal_year--;
						cal_month = 12;
						cal_day = 31;
					end
					n--;
				end
			end
			CMD_CMP: begin
				if (date_ok(c.day, c.month, c.year)) begin
					diff = julian_day(cal_day, cal_month, cal_year)
						- julian_day(c.day, c.month, c.year);
				end else begin
					err = ERR_DATE;
				end
			end
		endcase
		jd = julian_day(cal_day, cal_month, cal_year);
		r.cur_day = 5'(cal_day);
		r.cur_month = 4'(cal_month);
		r.cur_year = 14'(cal_year);
		r.day_number = 23'(jd);
		r.weekday = 3'(jd % 7);
		r.difference = 23'(diff);
		r.error = err;
		return r;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] expd,
		logic signed [31:0] got);
		if (got !== expd) begin
			$error("%s: expected %0d, got %0d", name, expd, got);
			fail_count++;
		end
	endfunction

	task automatic send_cmd(date_cmd_t c, logic typed, date_result_t want);
		date_result_t predicted;
		int gap;
		gap = $urandom_range(0, idle_max);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.command <= c.command;
		cmd.day_in <= c.day;
		cmd.month_in <= c.month;
		cmd.year_in <= c.year;
		cmd.day_count <= c.count;
		do @(posedge clk); while (!cmd.ready);
		predicted = advance_calendar(c);
		pending_results.push_back(typed ? want : predicted);
		beats_per_cmd[c.command]++;
	endtask

	initial begin : result_side
		date_result_t want;
		int stall;
		int stall_left;
		result.ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				result.ready <= 1'b0;
			end else if (result.valid && result.ready) begin
				if (result.error == ERR_DATE) begin
					date_errs++;
				end
				if (result.error == ERR_RANGE) begin
					range_stops++;
				end
				if (pending_results.size() == 0) begin
					$error("result beat with no command pending");
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					check_field("cur_day", want.cur_day, result.cur_day);
					check_field("cur_month", want.cur_month, result.cur_month);
					check_field("cur_year", want.cur_year, result.cur_year);
					check_field("day_number", want.day_number, result.day_number);
					check_field("weekday", want.weekday, result.weekday);
					check_field("difference", want.difference, result.difference);
					check_field("error", want.error, result.error);
				end
				stall = $urandom_range(0, idle_max);
				result.ready <= (stall == 0);
				stall_left = (stall > 0) ? stall - 1 : 0;
			end else if (!result.ready) begin
				if (stall_left == 0) begin
					result.ready <= 1'b1;
				end else begin
					stall_left--;
				end
			end
		end
	end

	initial begin : stimulus
		date_cmd_t c;
		int pick;
		int y;
		int m;
		arst_n <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.command <= CMD_SET;
		cmd.day_in <= 5'd0;
		cmd.month_in <= 4'd0;
		cmd.year_in <= 14'd0;
		cmd.day_count <= 16'd0;
		cal_day = 1;
		cal_month = 1;
		cal_year = 2000;
		idle_max = 4;
		large_left = 6;
		fail_count = 0;
		date_errs = 0;
		range_stops = 0;
		beats_per_cmd = '{0, 0, 0, 0};

		dir_rows = '{
			'{'{CMD_CMP, 5'd1, 4'd1, 14'd2000, 16'd0}, 1'b1, JAN_2000},
			'{'{CMD_SET, 5'd0, 4'd1, 14'd2000, 16'd0}, 1'b1, JAN_2000_BAD},
			'{'{CMD_SET, 5'd1, 4'd0, 14'd2000, 16'd0}, 1'b1, JAN_2000_BAD},
			'{'{CMD_SET, 5'd31, 4'd15, 14'd16383, 16'd65535}, 1'b1, JAN_2000_BAD},
			'{'{CMD_SET, 5'd1, 4'd1, 14'd0, 16'd0}, 1'b1, JAN_2000_BAD},
			'{'{CMD_SET, 5'd29, 4'd2, 14'd1900, 16'd0}, 1'b1, JAN_2000_BAD},
			'{'{CMD_SET, 5'd31, 4'd4, 14'd2023, 16'd0}, 1'b1, JAN_2000_BAD},
			'{'{CMD_CMP, 5'd30, 4'd2, 14'd2024, 16'd0}, 1'b1, JAN_2000_BAD},
			'{'{CMD_SET, 5'd29, 4'd2, 14'd2000, 16'd0}, 1'b0, '0},
			'{'{CMD_ADD, 5'd0, 4'd0, 14'd0, 16'd1}, 1'b0, '0},
			'{'{CMD_SUB, 5'd0, 4'd0, 14'd0, 16'd1}, 1'b0, '0},
			'{'{CMD_SET, 5'd31, 4'd12, 14'd9999, 16'd0}, 1'b1, LAST_DAY},
			'{'{CMD_ADD, 5'd0, 4'd0, 14'd0, 16'd1}, 1'b1, LAST_DAY_STOP},
			'{'{CMD_ADD, 5'd0, 4'd0, 14'd0, 16'd65535}, 1'b1, LAST_DAY_STOP},
			'{'{CMD_SET, 5'd1, 4'd1, 14'd1, 16'd0}, 1'b1, FIRST_DAY},
			'{'{CMD_SUB, 5'd0, 4'd0, 14'd0, 16'd1}, 1'b1, FIRST_DAY_STOP},
			'{'{CMD_SUB, 5'd0, 4'd0, 14'd0, 16'd65535}, 1'b1, FIRST_DAY_STOP},
			'{'{CMD_CMP, 5'd31, 4'd12, 14'd9999, 16'd0}, 1'b1, FIRST_VS_LAST},
			'{'{CMD_ADD, 5'd0, 4'd0, 14'd0, 16'd0}, 1'b1, FIRST_DAY},
			'{'{CMD_ADD, 5'd0, 4'd0, 14'd0, 16'd65535}, 1'b0, '0},
			'{'{CMD_SET, 5'd1, 4'd1, 14'd2001, 16'd0}, 1'b0, '0},
			'{'{CMD_SUB, 5'd0, 4'd0, 14'd0, 16'd1}, 1'b0, '0},
			'{'{CMD_SET, 5'd1, 4'd3, 14'd2100, 16'd0}, 1'b0, '0},
			'{'{CMD_SUB, 5'd0, 4'd0, 14'd0, 16'd1}, 1'b0, '0}
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_cmd(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// every other block of 25 beats runs with no gaps or stalls
			idle_max = ((i / 25) % 2 == 1) ? 0 : 4;
			pick = $urandom_range(0, 99);
			// mostly valid dates, some pinned near either end of the range
			if ($urandom_range(0, 9) == 0) begin
				y = ($urandom_range(0, 1) == 1) ? $urandom_range(9997, 9999)
					: $urandom_range(1, 3);
			end else begin
				y = $urandom_range(1, 9999);
			end
			m = $urandom_range(1, 12);
			c.year = 14'(y);
			c.month = 4'(m);
			c.day = 5'($urandom_range(1, month_length(y, m)));
			c.count = 16'($urandom_range(0, 400));
			// a handful of full-width counts keep the run length bounded
			if (large_left > 0 && $urandom_range(0, 15) == 0) begin
				c.count = 16'($urandom);
				large_left--;
			end
			if (pick < 30) begin
				c.command = CMD_SET;
			end else if (pick < 50) begin
				c.command = CMD_ADD;
			end else if (pick < 70) begin
				c.command = CMD_SUB;
			end else if (pick < 85) begin
				c.command = CMD_CMP;
			end else begin
				c.command = cmd_t'($urandom_range(0, 3));
				c.day = 5'($urandom);
				c.month = 4'($urandom);
				c.year = 14'($urandom);
				c.count = 16'($urandom_range(0, 31));
			end
			send_cmd(c, 1'b0, '0);
		end
		cmd.valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		// catch any stray beat after the last expected one
		repeat (50) @(posedge clk);

		$display("calendar_date_unit_top_tb: %0d set, %0d add, %0d subtract, %0d compare beats",
			beats_per_cmd[CMD_SET], beats_per_cmd[CMD_ADD], beats_per_cmd[CMD_SUB],
			beats_per_cmd[CMD_CMP]);
		$display("calendar_date_unit_top_tb: %0d invalid dates, %0d range stops, %0d bad fields",
			date_errs, range_stops, fail_count);
		if (fail_count == 0) begin
			$display("calendar_date_unit_top: match");
		end else begin
			$display("calendar_date_unit_top: mismatch");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("calendar_date_unit_top: mismatch");
		$finish;
	end

endmodule
